// ===== hdl/quaternion_to_euler_angles_core_macros.svh =====
// Assertion macros shared by the quaternion to Euler angle RTL.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg)
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/q2e_pkg.sv =====
// Types, constants and angle table for the quaternion to Euler angle core.
package q2e_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int Q14_W = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W = 36;
	localparam int SQ_ROOT_W = 27;
	localparam int SQ_REM_W = SQ_ROOT_W + 2;
	localparam int SQ_OP_W = 2 * SQ_ROOT_W;
	localparam int SQ_SHIFT = 20;
	localparam int CX_W = 38;
	localparam int Z_W = 24;
	localparam int RND_W = Z_W + 2;
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;
	localparam logic signed [RND_W-1:0] HALF_PI_Q20 = 26'sd1647099;
	localparam logic signed [SUM_W-1:0] ONE_Q28 = 36'sd268435456;
	localparam logic signed [RND_W-1:0] ANG_MAX = 26'sd12868;
	localparam logic signed [RND_W-1:0] PITCH_MAX = 26'sd6434;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_OP_W-1:0]   op;
	} sq_state_t;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} cd_state_t;

	// atan(2^-i) in Q.20
	function automatic logic signed [Z_W-1:0] atan_q20(input int i);
		case (i)
			0: atan_q20 = 24'sd823550;
			1: atan_q20 = 24'sd486170;
			2: atan_q20 = 24'sd256879;
			3: atan_q20 = 24'sd130396;
			4: atan_q20 = 24'sd65451;
			5: atan_q20 = 24'sd32757;
			6: atan_q20 = 24'sd16383;
			7: atan_q20 = 24'sd8192;
			8: atan_q20 = 24'sd4096;
			9: atan_q20 = 24'sd2048;
			10: atan_q20 = 24'sd1024;
			11: atan_q20 = 24'sd512;
			12: atan_q20 = 24'sd256;
			13: atan_q20 = 24'sd128;
			14: atan_q20 = 24'sd64;
			15: atan_q20 = 24'sd32;
			default: atan_q20 = '0;
		endcase
	endfunction
endpackage

// ===== hdl/q2e_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
module q2e_sqrt_cell (
	input  logic                clk,
	input  q2e_pkg::sq_state_t  d,
	output q2e_pkg::sq_state_t  q
);
	import q2e_pkg::*;

	logic [SQ_REM_W+1:0] cand;
	logic [SQ_REM_W+1:0] trial;
	sq_state_t           nxt;

	always_comb begin
		cand = {d.rem, d.op[SQ_OP_W-1 -: 2]};
		trial = {{(SQ_REM_W-SQ_ROOT_W){1'b0}}, d.root, 2'b01};
		nxt.op = {d.op[SQ_OP_W-3:0], 2'b00};
		if (cand >= trial) begin
			nxt.rem = SQ_REM_W'(cand - trial);
			nxt.root = {d.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = cand[SQ_REM_W-1:0];
			nxt.root = {d.root[SQ_ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

// ===== hdl/q2e_cordic_cell.sv =====
// One vectoring step of the CORDIC atan2 pipeline.
module q2e_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  q2e_pkg::cd_state_t  d,
	output q2e_pkg::cd_state_t  q
);
	import q2e_pkg::*;

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	cd_state_t              nxt;

	always_comb begin
		dx = d.x >>> STEP;
		dy = d.y >>> STEP;
		nxt.zero = d.zero;
		if (!d.y[CX_W-1]) begin
			nxt.x = d.x + dy;
			nxt.y = d.y - dx;
			nxt.z = d.z + atan_q20(STEP);
		end else begin
			nxt.x = d.x - dy;
			nxt.y = d.y + dx;
			nxt.z = d.z - atan_q20(STEP);
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

// ===== hdl/quaternion_to_euler_angles_core.sv =====
// Top level: quaternion to ZYX Euler angles, fully pipelined.
//
// Request channel: a quaternion (quat_w..quat_z, signed Q1.(DATA_WIDTH-2))
// is taken at each rising edge with start high and busy low. busy is held
// low, so one request may be issued every cycle.
// Result channel: done is high for one cycle with roll_angle, pitch_angle
// and yaw_angle (signed radians: Q2.12 roll and yaw, Q1.12 pitch). The
// receiver cannot stall; a result is valid only in its done cycle.
// done goes high once the request has passed 47 register stages, the
// first loaded at the edge that takes the request; one result per cycle
// sustained. The stages are the product and sum registers, the 27
// root-digit cells of the pitch square roots, one quadrant stage, the 16
// CORDIC vectoring cells and the output register.
// Pipeline: products, sums and clamp, root cells, quadrant fold, CORDIC
// cells, round and saturate. Results leave in request order.
// Reset clears the valid line only; data in flight is dropped and no
// strobe appears until new requests have passed the whole pipeline.
`include "quaternion_to_euler_angles_core_macros.svh"
module quaternion_to_euler_angles_core #(
	parameter int DATA_WIDTH = q2e_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] quat_w,
	input  logic signed [DATA_WIDTH-1:0] quat_x,
	input  logic signed [DATA_WIDTH-1:0] quat_y,
	input  logic signed [DATA_WIDTH-1:0] quat_z,
	output logic                         done,
	output logic signed [14:0]           roll_angle,
	output logic signed [13:0]           pitch_angle,
	output logic signed [14:0]           yaw_angle
);
	import q2e_pkg::*;

	// valid line: s1, s2, root cells, quadrant fold, CORDIC cells
	localparam int NV = 2 + SQ_ROOT_W + 1 + CORDIC_STEPS;
	localparam int PREP_IDX = 2 + SQ_ROOT_W;

	logic [NV-1:0] vld_q;
	logic          done_q;

	assign busy = 1'b0;

	// bring inputs to Q1.14 (floor when narrowing)
	logic signed [Q14_W-1:0] w14, x14, y14, z14;
	generate
		if (DATA_WIDTH >= Q14_W) begin : g_narrow
			assign w14 = quat_w[DATA_WIDTH-1 -: Q14_W];
			assign x14 = quat_x[DATA_WIDTH-1 -: Q14_W];
			assign y14 = quat_y[DATA_WIDTH-1 -: Q14_W];
			assign z14 = quat_z[DATA_WIDTH-1 -: Q14_W];
		end else begin : g_widen
			assign w14 = {quat_w, {(Q14_W-DATA_WIDTH){1'b0}}};
			assign x14 = {quat_x, {(Q14_W-DATA_WIDTH){1'b0}}};
			assign y14 = {quat_y, {(Q14_W-DATA_WIDTH){1'b0}}};
			assign z14 = {quat_z, {(Q14_W-DATA_WIDTH){1'b0}}};
		end
	endgenerate

	// stage 1: all nine products, exact Q.28
	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0] wz_s1, xy_s1, wy_s1, xz_s1;

	always_ff @(posedge clk) begin
		wx_s1 <= w14 * x14;
		yz_s1 <= y14 * z14;
		xx_s1 <= x14 * x14;
		yy_s1 <= y14 * y14;
		zz_s1 <= z14 * z14;
		wz_s1 <= w14 * z14;
		xy_s1 <= x14 * y14;
		wy_s1 <= w14 * y14;
		xz_s1 <= x14 * z14;
	end

	// stage 2: atan2 arguments, root arguments clamped at zero
	logic signed [SUM_W-1:0] sr_s2, cr_s2, sy_s2, cy_s2, a_s2, b_s2;
	logic signed [SUM_W-1:0] t2, a_c, b_c;

	always_comb begin
		t2 = (SUM_W'(wy_s1) - SUM_W'(xz_s1)) <<< 1;
		a_c = ONE_Q28 + t2;
		b_c = ONE_Q28 - t2;
		if (a_c[SUM_W-1]) a_c = '0;
		if (b_c[SUM_W-1]) b_c = '0;
	end

	always_ff @(posedge clk) begin
		sr_s2 <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
		cr_s2 <= ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
		sy_s2 <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
		cy_s2 <= ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
		a_s2 <= a_c;
		b_s2 <= b_c;
	end

	// root cells: floor(sqrt(v * 2^20)), one result bit per cell
	sq_state_t sqa[SQ_ROOT_W+1];
	sq_state_t sqb[SQ_ROOT_W+1];

	assign sqa[0] = '{rem: '0, root: '0,
		op: {a_s2[SQ_OP_W-SQ_SHIFT-1:0], {SQ_SHIFT{1'b0}}}};
	assign sqb[0] = '{rem: '0, root: '0,
		op: {b_s2[SQ_OP_W-SQ_SHIFT-1:0], {SQ_SHIFT{1'b0}}}};

	// roll and yaw arguments wait alongside the root cells
	logic signed [SUM_W-1:0] dsr_q[SQ_ROOT_W+1];
	logic signed [SUM_W-1:0] dcr_q[SQ_ROOT_W+1];
	logic signed [SUM_W-1:0] dsy_q[SQ_ROOT_W+1];
	logic signed [SUM_W-1:0] dcy_q[SQ_ROOT_W+1];

	assign dsr_q[0] = sr_s2;
	assign dcr_q[0] = cr_s2;
	assign dsy_q[0] = sy_s2;
	assign dcy_q[0] = cy_s2;

	genvar gi;
	generate
		for (gi = 0; gi < SQ_ROOT_W; gi++) begin : g_sq
			q2e_sqrt_cell u_sqa (.clk(clk), .d(sqa[gi]), .q(sqa[gi+1]));
			q2e_sqrt_cell u_sqb (.clk(clk), .d(sqb[gi]), .q(sqb[gi+1]));
			always_ff @(posedge clk) begin
				dsr_q[gi+1] <= dsr_q[gi];
				dcr_q[gi+1] <= dcr_q[gi];
				dsy_q[gi+1] <= dsy_q[gi];
				dcy_q[gi+1] <= dcy_q[gi];
			end
		end
	endgenerate

	// quadrant fold: left half plane turned by pi, zero vector flagged
	function automatic cd_state_t fold(input logic signed [CX_W-1:0] yv,
			input logic signed [CX_W-1:0] xv);
		cd_state_t r;
		r.zero = (xv == '0) && (yv == '0);
		r.x = xv;
		r.y = yv;
		r.z = '0;
		if (xv[CX_W-1]) begin
			r.z = yv[CX_W-1] ? -PI_Q20 : PI_Q20;
			r.x = -xv;
			r.y = -yv;
		end
		return r;
	endfunction

	cd_state_t cdr[CORDIC_STEPS+1];
	cd_state_t cdp[CORDIC_STEPS+1];
	cd_state_t cdy[CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		cdr[0] <= fold(CX_W'(dsr_q[SQ_ROOT_W]), CX_W'(dcr_q[SQ_ROOT_W]));
		cdy[0] <= fold(CX_W'(dsy_q[SQ_ROOT_W]), CX_W'(dcy_q[SQ_ROOT_W]));
		cdp[0] <= fold({{(CX_W-SQ_ROOT_W){1'b0}}, sqa[SQ_ROOT_W].root},
			{{(CX_W-SQ_ROOT_W){1'b0}}, sqb[SQ_ROOT_W].root});
	end

	generate
		for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cd
			q2e_cordic_cell #(.STEP(gi)) u_cdr (.clk(clk), .d(cdr[gi]), .q(cdr[gi+1]));
			q2e_cordic_cell #(.STEP(gi)) u_cdp (.clk(clk), .d(cdp[gi]), .q(cdp[gi+1]));
			q2e_cordic_cell #(.STEP(gi)) u_cdy (.clk(clk), .d(cdy[gi]), .q(cdy[gi+1]));
		end
	endgenerate

	// Q.20 to Q.12, round half up, saturate to +-lim
	function automatic logic signed [RND_W-1:0] rnd_sat(
			input logic signed [RND_W-1:0] v, input logic signed [RND_W-1:0] lim);
		logic signed [RND_W-1:0] r;
		r = (v + RND_W'(128)) >>> 8;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	logic signed [Z_W-1:0]   zr, zp, zy;
	logic signed [RND_W-1:0] rr, rp, ry;

	always_comb begin
		zr = cdr[CORDIC_STEPS].zero ? '0 : cdr[CORDIC_STEPS].z;
		zp = cdp[CORDIC_STEPS].zero ? '0 : cdp[CORDIC_STEPS].z;
		zy = cdy[CORDIC_STEPS].zero ? '0 : cdy[CORDIC_STEPS].z;
		rr = rnd_sat(RND_W'(zr), ANG_MAX);
		ry = rnd_sat(RND_W'(zy), ANG_MAX);
		// pitch = 2*atan - pi/2
		rp = rnd_sat((RND_W'(zp) <<< 1) - HALF_PI_Q20, PITCH_MAX);
	end

	always_ff @(posedge clk) begin
		roll_angle <= rr[14:0];
		pitch_angle <= rp[13:0];
		yaw_angle <= ry[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[NV-2:0], start & ~busy};
			done_q <= vld_q[NV-1];
		end
	end

	assign done = done_q;

	`Q2E_ASSERT_IMP(a_fold_pos, vld_q[PREP_IDX], !cdr[0].x[CX_W-1] && !cdp[0].x[CX_W-1] && !cdy[0].x[CX_W-1], "folded x negative")
	`Q2E_ASSERT_IMP(a_pitch_rng, done, (pitch_angle <= 14'sd6434) && (pitch_angle >= -14'sd6434), "pitch out of range")
	`Q2E_ASSERT_IMP(a_ang_rng, done, (roll_angle <= 15'sd12868) && (roll_angle >= -15'sd12868) && (yaw_angle <= 15'sd12868) && (yaw_angle >= -15'sd12868), "roll or yaw out of range")
endmodule

// ===== dv/tb_quaternion_to_euler_angles_core.sv =====
// Self-checking testbench for the quaternion to ZYX Euler angle core.
module tb_quaternion_to_euler_angles_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = q2e_pkg::DATA_WIDTH_DEF;
	localparam int LATENCY = 47;
	localparam int N_RANDOM = 1930;

	// expected Euler angles for one request
	typedef struct {
		logic signed [14:0] roll;
		logic signed [13:0] pitch;
		logic signed [14:0] yaw;
	} euler_t;

	// floor shift for 64-bit signed values
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// vectoring CORDIC, angle in Q.20
	function automatic longint vec_atan2(longint y, longint x);
		longint ang;
		longint dx;
		longint dy;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			ang = (y >= 0) ? longint'(q2e_pkg::PI_Q20) : -longint'(q2e_pkg::PI_Q20);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin
			dx = fshr(x, i);
			dy = fshr(y, i);
			if (y >= 0) begin
				x = x + dy;
				y = y - dx;
				ang = ang + longint'(q2e_pkg::atan_q20(i));
			end else begin
				x = x - dy;
				y = y + dx;
				ang = ang - longint'(q2e_pkg::atan_q20(i));
			end
		end
		return ang;
	endfunction

	// Q.20 to Q.12 with round half up and saturation
	function automatic longint round_sat(longint a, longint lim);
		longint r;
		r = fshr(a + 128, 8);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic euler_t quat_to_euler(logic signed [DW-1:0] qw, logic signed [DW-1:0] qx,
			logic signed [DW-1:0] qy, logic signed [DW-1:0] qz);
		euler_t e;
		longint w, x, y, z, one, sr, cr, sy, cy, t, a, b;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		one = 64'sd1 <<< 28;
		sr = 2 * (w * x + y * z);
		cr = one - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = one - 2 * (y * y + z * z);
		t = w * y - x * z;
		a = one + 2 * t;
		b = one - 2 * t;
		// unnormalized input: negative root argument clamps to zero
		if (a < 0)
			a = 0;
		if (b < 0)
			b = 0;
		a = int_sqrt(a <<< 20);
		b = int_sqrt(b <<< 20);
		e.roll = 15'(round_sat(vec_atan2(sr, cr), 12868));
		e.pitch = 14'(round_sat(2 * vec_atan2(a, b) - longint'(q2e_pkg::HALF_PI_Q20), 6434));
		e.yaw = 15'(round_sat(vec_atan2(sy, cy), 12868));
		return e;
	endfunction

	// holds predicted angles in request order and checks arrivals
	class euler_scoreboard;
		euler_t pending[$];
		int errors = 0;

		function void note_request(logic signed [DW-1:0] qw, logic signed [DW-1:0] qx,
				logic signed [DW-1:0] qy, logic signed [DW-1:0] qz);
			pending.push_back(quat_to_euler(qw, qx, qy, qz));
		endfunction

		function void check_angles(logic signed [14:0] roll, logic signed [13:0] pitch,
				logic signed [14:0] yaw);
			euler_t e;
			if (pending.size() == 0) begin
				$error("unexpected result roll=%0d pitch=%0d yaw=%0d", roll, pitch, yaw);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (roll !== e.roll) begin
				$error("roll_angle expected %0d actual %0d", e.roll, roll);
				errors++;
			end
			if (pitch !== e.pitch) begin
				$error("pitch_angle expected %0d actual %0d", e.pitch, pitch);
				errors++;
			end
			if (yaw !== e.yaw) begin
				$error("yaw_angle expected %0d actual %0d", e.yaw, yaw);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DW-1:0] quat_w, quat_x, quat_y, quat_z;
	logic done;
	logic signed [14:0] roll_angle;
	logic signed [13:0] pitch_angle;
	logic signed [14:0] yaw_angle;

	euler_scoreboard sb = new();
	bit quiet_phase = 0;

	quaternion_to_euler_angles_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.done(done),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// results cannot be held off, so every done cycle is checked
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_angles(roll_angle, pitch_angle, yaw_angle);
	end

	// issue one request; start stays high across back-to-back requests
	task automatic send_request(logic signed [DW-1:0] qw, logic signed [DW-1:0] qx,
			logic signed [DW-1:0] qy, logic signed [DW-1:0] qz);
		// random idle cycles ahead of the request, none in the quiet phase
		if (!quiet_phase && $urandom_range(99) < 5) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		quat_w <= qw;
		quat_x <= qx;
		quat_y <= qy;
		quat_z <= qz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(qw, qx, qy, qz);
	endtask

	function automatic logic signed [DW-1:0] rand_comp();
		// mostly in-range values, sometimes any 16-bit pattern
		if ($urandom_range(9) == 0)
			return DW'($urandom);
		return DW'($signed($urandom_range(32768)) - 16384);
	endfunction

	task automatic send_unit_quat();
		// random unit quaternion via float normalization
		real a, b, c, d, n;
		a = $signed($urandom_range(2000)) - 1000;
		b = $signed($urandom_range(2000)) - 1000;
		c = $signed($urandom_range(2000)) - 1000;
		d = $signed($urandom_range(2000)) - 1000;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n == 0.0) begin
			a = 1.0;
			n = 1.0;
		end
		send_request(DW'($rtoi(a / n * 16384.0)), DW'($rtoi(b / n * 16384.0)),
			DW'($rtoi(c / n * 16384.0)), DW'($rtoi(d / n * 16384.0)));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		real h;
		start = 1'b0;
		quat_w = '0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		h = 11585.0; // cos(pi/4) in Q1.14

		// directed: identity, axis rotations, gimbal lock, extremes
		send_request(16384, 0, 0, 0);
		send_request(-16384, 0, 0, 0);
		send_request(0, 16384, 0, 0);
		send_request(0, 0, 16384, 0);
		send_request(0, 0, 0, 16384);
		send_request(0, -16384, 0, 0);
		send_request(0, 0, -16384, 0);
		send_request(0, 0, 0, -16384);
		// pitch at +-90 degrees
		send_request(DW'($rtoi(h)), 0, DW'($rtoi(h)), 0);
		send_request(DW'($rtoi(h)), 0, -DW'($rtoi(h)), 0);
		send_request(8192, 8192, 8192, 8192);
		send_request(8192, -8192, 8192, -8192);
		// zero quaternion and pitch root arguments clamped
		send_request(0, 0, 0, 0);
		send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_request(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_request(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_request(16'sh7fff, 0, 16'sh7fff, 0);
		send_request(16'sh7fff, 0, 16'sh8000, 0);
		send_request(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001);
		send_request(16384, 16384, 16384, 16384);
		send_request(-16384, -16384, -16384, -16384);

		// pressure: hold off until the pipeline has drained
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_phase = (i >= 600 && i < 900);
			if ($urandom_range(3) != 0)
				send_unit_quat();
			else
				send_request(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (sb.errors == 0)
			$display("quaternion_to_euler_angles_core test passed");
		else
			$display("quaternion_to_euler_angles_core test failed");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("quaternion_to_euler_angles_core test failed");
		$finish;
	end
endmodule
